// File: hw/rtl/cbsp_pkg.sv
// shared types, constants and codes of the cubic bezier stroke plotter
`default_nettype none

package cbsp_pkg;

  localparam int FULL_DIVISIONS_DEF = 400;
  localparam int MAX_DIM_DEF        = 1024;

  localparam int DIM_W  = 11;
  localparam int FRAC_W = 16;
  localparam int PT_W   = 20;
  localparam int IDX_W  = 9;
  localparam int PIX_W  = 12;

  localparam int DIV_N_W = 52;
  localparam int DIV_D_W = 36;
  localparam int DIV_Q_W = 22;

  localparam logic [FRAC_W-1:0] QUARTER_LIMIT    = 16'd39322;
  localparam logic [FRAC_W-1:0] HALF_LIMIT       = 16'd58983;
  localparam logic [FRAC_W-1:0] HALF_OPTION      = 16'd32768;
  localparam logic [FRAC_W-1:0] THIRD_OPTION     = 16'd21824;
  localparam logic [FRAC_W-1:0] TWO_THIRD_OPTION = 16'd43647;

  localparam logic [1:0] MODE_BLACK = 2'd0;
  localparam logic [1:0] MODE_BW    = 2'd1;
  localparam logic [1:0] MODE_BR    = 2'd2;
  localparam logic [1:0] MODE_BRW   = 2'd3;

  typedef enum logic [1:0] {
    COLOR_BLACK = 2'd0,
    COLOR_WHITE = 2'd1,
    COLOR_RED   = 2'd2
  } color_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_TIP    = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    LEN_QUARTER = 2'd0,
    LEN_HALF    = 2'd1,
    LEN_FULL    = 2'd2
  } len_e;

  typedef struct packed {
    logic              action;
    logic [FRAC_W-1:0] length_fraction;
    logic [FRAC_W-1:0] end1_fraction;
    logic [FRAC_W-1:0] end2_fraction;
    logic [FRAC_W-1:0] ctrl1_fraction;
    logic [FRAC_W-1:0] ctrl2_fraction;
    logic [FRAC_W-1:0] color_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [1:0]              color_code;
    logic                    write_enable;
    logic                    last_in_run;
    logic                    stroke_done;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [1:0]       color_mode;
    logic             single_pixel_tip;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                   is_step;
    len_e                   len;
    color_e                 color;
    logic [3:0][FRAC_W-1:0] frac;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/cubic_bezier_stroke_plotter.sv
// top level of the cubic bezier stroke plotter: configuration registers and the two halves
`default_nettype none

// usage
// - in channel (valid/ready): each request either loads a stroke (action 0) or steps it
//   to the next curve point (action 1); a two-entry queue sits in front of the engine
// - out channel (valid/ready): a step gives one pixel, or nine for the 3x3 pencil tip
//   (dx outer, dy inner), the last one flagged by last_in_run
// - configuration: plain write port, register index 0 width, 1 height, 2 color mode,
//   3 single pixel tip; write only while the block is idle
// - a load passes through acceptance, the multiplier, a square root, four divisions that
//   split pixel indices into x and y, and a final step that places the points
// - a step passes through acceptance, the shared multiplier for the Bezier weights and
//   sums, then two divisions by N^3*256, and then emits its pixels
// - the serial divider (one quotient bit a cycle) takes up most of a load and of a step
// - one request is worked on at a time; new requests queue while the engine runs
// - reset: control and configuration registers take their reset values, stroke idle, no output pending
// - when the receiver stalls the finished pixel waits in the output register and
//   the engine holds
module cubic_bezier_stroke_plotter import cbsp_pkg::*; #(
  parameter int FULL_DIVISIONS = FULL_DIVISIONS_DEF,
  parameter int MAX_DIM        = MAX_DIM_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [DIM_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_rsp_o
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width            <= DIM_W'(256);
      cfg_q.height           <= DIM_W'(256);
      cfg_q.color_mode       <= MODE_BLACK;
      cfg_q.single_pixel_tip <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH: cfg_q.width <= cfg_wdata_i;
        REG_HEIGHT: cfg_q.height <= cfg_wdata_i;
        REG_MODE: cfg_q.color_mode <= cfg_wdata_i[1:0];
        REG_TIP: cfg_q.single_pixel_tip <= cfg_wdata_i[0];
      endcase
    end
  end

  // front: classify requests and queue them
  cbsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // back: map points, evaluate the curve, emit pixels
  cbsp_back #(
    .FULL_DIVISIONS(FULL_DIVISIONS),
    .MAX_DIM       (MAX_DIM)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/cbsp_front.sv
// request intake: classification of load and step requests and a two-entry queue
`default_nettype none

module cbsp_front import cbsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_req_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);

  cmd_t       cls;
  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_comb begin
    cls.is_step = in_req_i.action;
    if (in_req_i.length_fraction < QUARTER_LIMIT) begin
      cls.len = LEN_QUARTER;
    end else if (in_req_i.length_fraction < HALF_LIMIT) begin
      cls.len = LEN_HALF;
    end else begin
      cls.len = LEN_FULL;
    end
    unique case (cfg_i.color_mode)
      MODE_BLACK: cls.color = COLOR_BLACK;
      MODE_BW: cls.color = (in_req_i.color_fraction < HALF_OPTION) ? COLOR_BLACK : COLOR_WHITE;
      MODE_BR: cls.color = (in_req_i.color_fraction < HALF_OPTION) ? COLOR_BLACK : COLOR_RED;
      MODE_BRW: begin
        if (in_req_i.color_fraction < THIRD_OPTION) begin
          cls.color = COLOR_BLACK;
        end else if (in_req_i.color_fraction < TWO_THIRD_OPTION) begin
          cls.color = COLOR_RED;
        end else begin
          cls.color = COLOR_WHITE;
        end
      end
    endcase
    cls.frac[0] = in_req_i.end1_fraction;
    cls.frac[1] = in_req_i.end2_fraction;
    cls.frac[2] = in_req_i.ctrl1_fraction;
    cls.frac[3] = in_req_i.ctrl2_fraction;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cbsp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module cbsp_div import cbsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int SH_W  = DIV_D_W + DIV_Q_W - 1;
  localparam int CNT_W = $clog2(DIV_Q_W);

  logic               run_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_N_W-1:0] rem_q;
  logic [SH_W-1:0]    dsh_q;
  logic [DIV_Q_W-1:0] quot_q;
  logic               fits;

  assign fits = ({{(SH_W - DIV_N_W){1'b0}}, rem_q} >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.dividend;
      dsh_q  <= {req_i.divisor, {(DIV_Q_W - 1){1'b0}}};
      quot_q <= '0;
    end else if (run_q) begin
      if (fits) rem_q <= rem_q - dsh_q[DIV_N_W-1:0];
      quot_q <= {quot_q[DIV_Q_W-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIV_Q_W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[DIV_D_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/cbsp_back.sv
// stroke engine: point mapping, curve evaluation and pixel emission
`default_nettype none

module cbsp_back import cbsp_pkg::*; #(
  parameter int FULL_DIVISIONS = FULL_DIVISIONS_DEF,
  parameter int MAX_DIM        = MAX_DIM_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_item_t out_rsp_o
);

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
  localparam logic [IDX_W-1:0] N_QUARTER = IDX_W'(FULL_DIVISIONS / 4);
  localparam logic [IDX_W-1:0] N_HALF    = IDX_W'(FULL_DIVISIONS / 2);
  localparam logic [IDX_W-1:0] N_FULL    = IDX_W'(FULL_DIVISIONS);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LMUL = 8'b0000_0010,
    ST_SQRT = 8'b0000_0100,
    ST_LDIV = 8'b0000_1000,
    ST_LFIN = 8'b0001_0000,
    ST_SMUL = 8'b0010_0000,
    ST_SDIV = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic [4:0] cnt_q;
  logic [1:0] k_q;
  logic       busy_q;

  // stroke state
  logic signed [PT_W-1:0] pt_x_q [4];
  logic signed [PT_W-1:0] pt_y_q [4];
  logic [IDX_W-1:0] idx_q, ndiv_q;
  color_e color_q;
  logic   active_q;

  // load scratch
  logic [21:0] size_q, sq2_q;
  logic [21:0] pidx_q [4];
  logic [DIM_W-1:0] root_q;
  logic signed [12:0] pix_x_q [4];
  logic signed [12:0] pix_y_q [4];

  // step scratch
  logic [17:0] aa_q, bb_q, ab_q, nn_q;
  logic [27:0] w0_q, w1_q, w2_q, w3_q;
  logic [26:0] n3_q;
  logic signed [49:0] numx_q, numy_q;
  logic signed [12:0] fx_q, fy_q;
  logic rx_q, ry_q, step_done_q, single_q, idle_emit_q;
  logic signed [1:0] dx_q, dy_q;

  logic      out_valid_q;
  out_item_t out_q;

  // shared multiplier
  logic signed [28:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [49:0] prod_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DIM_W-1:0] w_eff, h_eff, dvsr, off;
  logic [IDX_W-1:0] n_v, b_v, a_v;
  logic full;
  logic [21:0] ssize;
  logic [1:0]  fsel;
  logic [DIM_W-1:0] tbit;
  logic [21:0] tsq;
  logic [49:0] absnum;
  logic        negnum;
  logic [12:0] q13;
  logic        rnz;
  logic signed [12:0] fval;
  logic signed [12:0] lx, ly;
  logic signed [12:0] d_x [4];
  logic signed [12:0] d_y [4];
  logic signed [20:0] sum_x [4];
  logic signed [20:0] sum_y [4];
  logic signed [1:0] hi, lo;
  logic signed [13:0] vx, vy, pxv, pyv;
  logic we, last, emit_go;

  cbsp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > MAX_DIM_V) return MAX_DIM_V;
    return v;
  endfunction

  always_comb begin
    w_eff = eff_dim(cfg_i.width);
    h_eff = eff_dim(cfg_i.height);
    full  = (cmd_q.len == LEN_FULL);
    off   = (root_q - w_eff) >> 1;
    dvsr  = full ? root_q : w_eff;
    ssize = full ? {size_q[20:0], 1'b0} : size_q;
    fsel  = cnt_q[1:0] - 2'd2;
    tbit  = root_q | (DIM_W'(1) << cnt_q[3:0]);
    tsq   = tbit * tbit;
    n_v   = (ndiv_q == '0) ? IDX_W'(1) : ndiv_q;
    b_v   = (idx_q > n_v) ? n_v : idx_q;
    a_v   = n_v - b_v;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_LMUL) begin
      unique case (cnt_q)
        5'd0: begin mul_a = {18'd0, w_eff}; mul_b = {10'd0, h_eff}; end
        5'd1: begin mul_a = {18'd0, w_eff}; mul_b = {10'd0, w_eff}; end
        5'd2, 5'd3, 5'd4, 5'd5: begin
          mul_a = {7'd0, ssize};
          mul_b = {5'd0, cmd_q.frac[fsel]};
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == ST_SMUL) begin
      unique case (cnt_q)
        5'd0: begin mul_a = {20'd0, a_v}; mul_b = {12'd0, a_v}; end
        5'd1: begin mul_a = {20'd0, b_v}; mul_b = {12'd0, b_v}; end
        5'd2: begin mul_a = {20'd0, a_v}; mul_b = {12'd0, b_v}; end
        5'd3: begin mul_a = {20'd0, n_v}; mul_b = {12'd0, n_v}; end
        5'd4: begin mul_a = {11'd0, aa_q}; mul_b = {12'd0, a_v}; end
        5'd5: begin mul_a = {11'd0, bb_q}; mul_b = {12'd0, b_v}; end
        5'd6: begin mul_a = {11'd0, ab_q}; mul_b = {12'd0, a_v}; end
        5'd7: begin mul_a = {11'd0, ab_q}; mul_b = {12'd0, b_v}; end
        5'd8: begin mul_a = {11'd0, nn_q}; mul_b = {12'd0, n_v}; end
        5'd9: begin mul_a = {1'b0, w0_q}; mul_b = {pt_x_q[0][PT_W-1], pt_x_q[0]}; end
        5'd10: begin mul_a = {1'b0, w1_q}; mul_b = {pt_x_q[2][PT_W-1], pt_x_q[2]}; end
        5'd11: begin mul_a = {1'b0, w2_q}; mul_b = {pt_x_q[3][PT_W-1], pt_x_q[3]}; end
        5'd12: begin mul_a = {1'b0, w3_q}; mul_b = {pt_x_q[1][PT_W-1], pt_x_q[1]}; end
        5'd13: begin mul_a = {1'b0, w0_q}; mul_b = {pt_y_q[0][PT_W-1], pt_y_q[0]}; end
        5'd14: begin mul_a = {1'b0, w1_q}; mul_b = {pt_y_q[2][PT_W-1], pt_y_q[2]}; end
        5'd15: begin mul_a = {1'b0, w2_q}; mul_b = {pt_y_q[3][PT_W-1], pt_y_q[3]}; end
        5'd16: begin mul_a = {1'b0, w3_q}; mul_b = {pt_y_q[1][PT_W-1], pt_y_q[1]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider requests and result shaping
  always_comb begin
    negnum = (k_q == 2'd0) ? numx_q[49] : numy_q[49];
    absnum = (k_q == 2'd0) ? (numx_q[49] ? 50'(-numx_q) : numx_q)
                           : (numy_q[49] ? 50'(-numy_q) : numy_q);
    div_req.start = ((state_q == ST_LDIV) || (state_q == ST_SDIV)) && !busy_q;
    if (state_q == ST_LDIV) begin
      div_req.dividend = {30'd0, pidx_q[k_q]};
      div_req.divisor  = {25'd0, dvsr};
    end else begin
      div_req.dividend = {2'd0, absnum};
      div_req.divisor  = {1'b0, n3_q, 8'd0};
    end
    q13  = {1'b0, div_rsp.quot[11:0]};
    rnz  = |div_rsp.rem;
    fval = negnum ? (13'sd0 - $signed(q13) - $signed({12'd0, rnz})) : $signed(q13);
    if (full) begin
      lx = $signed({2'b0, div_rsp.rem[10:0]}) - $signed({2'b0, off});
      ly = $signed(q13) - $signed({2'b0, off});
    end else begin
      lx = $signed({2'b0, div_rsp.rem[10:0]});
      ly = $signed(q13);
    end
  end

  // final point placement: shrink toward the first end point, or scale up
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_x[i] = pix_x_q[i] - pix_x_q[0];
      d_y[i] = pix_y_q[i] - pix_y_q[0];
      if (full) begin
        sum_x[i] = {pix_x_q[i], 8'd0};
        sum_y[i] = {pix_y_q[i], 8'd0};
      end else if (cmd_q.len == LEN_QUARTER) begin
        sum_x[i] = {pix_x_q[0], 8'd0} + {{2{d_x[i][12]}}, d_x[i], 6'd0};
        sum_y[i] = {pix_y_q[0], 8'd0} + {{2{d_y[i][12]}}, d_y[i], 6'd0};
      end else begin
        sum_x[i] = {pix_x_q[0], 8'd0} + {d_x[i][12], d_x[i], 7'd0};
        sum_y[i] = {pix_y_q[0], 8'd0} + {d_y[i][12], d_y[i], 7'd0};
      end
    end
  end

  // pencil tip pixel
  always_comb begin
    hi   = single_q ? 2'sd0 : 2'sd1;
    lo   = single_q ? 2'sd0 : -2'sd1;
    vx   = {fx_q[12], fx_q} + {{12{dx_q[1]}}, dx_q};
    vy   = {fy_q[12], fy_q} + {{12{dy_q[1]}}, dy_q};
    pxv  = vx + {13'd0, vx[13] & rx_q};
    pyv  = vy + {13'd0, vy[13] & ry_q};
    we   = !idle_emit_q && !vx[13] && !vy[13] &&
           (pxv < $signed({3'd0, w_eff})) && (pyv < $signed({3'd0, h_eff}));
    last = (dx_q == hi) && (dy_q == hi);
    emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    if (state_q == ST_LMUL) begin
      unique case (cnt_q)
        5'd1: size_q <= prod_q[21:0];
        5'd2: sq2_q  <= {prod_q[20:0], 1'b0};
        5'd3, 5'd4, 5'd5, 5'd6: pidx_q[cnt_q[1:0] - 2'd3] <= prod_q[37:16];
        default: ;
      endcase
    end
    if (state_q == ST_SQRT && tsq <= sq2_q) root_q <= tbit;
    if (state_q == ST_LMUL) root_q <= '0;
    if (state_q == ST_LDIV && div_rsp.done) begin
      pix_x_q[k_q] <= lx;
      pix_y_q[k_q] <= ly;
    end
    if (state_q == ST_SMUL) begin
      unique case (cnt_q)
        5'd1: aa_q <= prod_q[17:0];
        5'd2: bb_q <= prod_q[17:0];
        5'd3: ab_q <= prod_q[17:0];
        5'd4: nn_q <= prod_q[17:0];
        5'd5: w0_q <= prod_q[27:0];
        5'd6: w3_q <= prod_q[27:0];
        5'd7: w1_q <= prod_q[27:0] + {prod_q[26:0], 1'b0};
        5'd8: w2_q <= prod_q[27:0] + {prod_q[26:0], 1'b0};
        5'd9: n3_q <= prod_q[26:0];
        5'd10, 5'd11, 5'd12, 5'd13: numx_q <= numx_q + prod_q;
        5'd14, 5'd15, 5'd16, 5'd17: numy_q <= numy_q + prod_q;
        default: ;
      endcase
    end
    if (state_q == ST_IDLE) begin
      numx_q <= '0;
      numy_q <= '0;
      fx_q   <= '0;
      fy_q   <= '0;
      rx_q   <= 1'b0;
      ry_q   <= 1'b0;
    end
    if (state_q == ST_SDIV && div_rsp.done) begin
      if (k_q == 2'd0) begin
        fx_q <= fval;
        rx_q <= rnz;
      end else begin
        fy_q <= fval;
        ry_q <= rnz;
      end
    end
    if (emit_go) begin
      out_q.pixel_x      <= pxv[PIX_W-1:0];
      out_q.pixel_y      <= pyv[PIX_W-1:0];
      out_q.color_code   <= color_q;
      out_q.write_enable <= we;
      out_q.last_in_run  <= last;
      out_q.stroke_done  <= step_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      ndiv_q      <= '0;
      color_q     <= COLOR_BLACK;
      active_q    <= 1'b0;
      step_done_q <= 1'b0;
      single_q    <= 1'b0;
      idle_emit_q <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pt_x_q[i] <= '0;
        pt_y_q[i] <= '0;
      end
    end else begin
      if (div_req.start) busy_q <= 1'b1;
      if (div_rsp.done) busy_q <= 1'b0;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          k_q   <= '0;
          if (cmd_valid_i) begin
            if (!cmd_i.is_step) begin
              state_q <= ST_LMUL;
            end else if (active_q) begin
              state_q     <= ST_SMUL;
              idle_emit_q <= 1'b0;
              single_q    <= cfg_i.single_pixel_tip;
              step_done_q <= (idx_q >= n_v);
            end else begin
              state_q     <= ST_EMIT;
              idle_emit_q <= 1'b1;
              single_q    <= 1'b1;
              step_done_q <= 1'b1;
              dx_q        <= '0;
              dy_q        <= '0;
            end
          end
        end
        ST_LMUL: begin
          if (cnt_q == 5'd6) begin
            state_q <= ST_SQRT;
            cnt_q   <= 5'd10;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SQRT: begin
          if (cnt_q == '0) begin
            state_q <= ST_LDIV;
            k_q     <= '0;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_LDIV: begin
          if (div_rsp.done) begin
            k_q <= k_q + 2'd1;
            if (k_q == 2'd3) state_q <= ST_LFIN;
          end
        end
        ST_LFIN: begin
          for (int i = 0; i < 4; i++) begin
            pt_x_q[i] <= sum_x[i][PT_W-1:0];
            pt_y_q[i] <= sum_y[i][PT_W-1:0];
          end
          unique case (cmd_q.len)
            LEN_QUARTER: ndiv_q <= N_QUARTER;
            LEN_HALF: ndiv_q <= N_HALF;
            default: ndiv_q <= N_FULL;
          endcase
          color_q  <= cmd_q.color;
          idx_q    <= '0;
          active_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
        ST_SMUL: begin
          if (cnt_q == 5'd17) begin
            state_q <= ST_SDIV;
            k_q     <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SDIV: begin
          if (div_rsp.done) begin
            if (k_q == 2'd0) begin
              k_q <= 2'd1;
            end else begin
              state_q <= ST_EMIT;
              dx_q    <= lo;
              dy_q    <= lo;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (last) begin
              state_q <= ST_IDLE;
              if (!idle_emit_q) begin
                if (step_done_q) begin
                  active_q <= 1'b0;
                end else begin
                  idx_q <= idx_q + IDX_W'(1);
                end
              end
            end else if (dy_q == hi) begin
              dy_q <= lo;
              dx_q <= dx_q + 2'sd1;
            end else begin
              dy_q <= dy_q + 2'sd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sim/cubic_bezier_stroke_plotter_tb.sv
// self-checking testbench of the cubic bezier stroke plotter
`timescale 1ns / 100ps

module cubic_bezier_stroke_plotter_tb;
  import cbsp_pkg::*;

  // pixel predictor and store of expected pixels
  class stroke_scoreboard;
    longint canvas_w, canvas_h;
    logic [1:0] mode;
    bit one_pixel;
    longint e1x, e1y, e2x, e2y, c1x, c1y, c2x, c2y;
    longint point_no, divisions;
    color_e pen_color;
    bit drawing;
    out_item_t expected_pixels[$];
    int mismatches;
    int pixels_seen;

    function new();
      canvas_w = 256;
      canvas_h = 256;
      mode = MODE_BLACK;
      one_pixel = 0;
      {e1x, e1y, e2x, e2y, c1x, c1y, c2x, c2y} = '0;
      point_no = 0;
      divisions = 0;
      pen_color = COLOR_BLACK;
      drawing = 0;
      mismatches = 0;
      pixels_seen = 0;
    endfunction

    function longint clamp_dim(longint v);
      if (v < 1) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    function void set_reg(reg_e idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_WIDTH:  canvas_w = val;
        REG_HEIGHT: canvas_h = val;
        REG_MODE:   mode = val[1:0];
        REG_TIP:    one_pixel = val[0];
        default: ;
      endcase
    endfunction

    function void load_stroke(in_item_t it);
      longint w, h, sz, p, vw, off, sc, sx, sy;
      longint px[4], py[4];
      logic [FRAC_W-1:0] fr[4];
      w = clamp_dim(canvas_w);
      h = clamp_dim(canvas_h);
      sz = w * h;
      fr[0] = it.end1_fraction;
      fr[1] = it.end2_fraction;
      fr[2] = it.ctrl1_fraction;
      fr[3] = it.ctrl2_fraction;
      if (it.length_fraction < HALF_LIMIT) begin
        // quarter and half strokes shrink toward the first end point
        sc = (it.length_fraction < QUARTER_LIMIT) ? 64 : 128;
        divisions = (it.length_fraction < QUARTER_LIMIT) ? FULL_DIVISIONS_DEF / 4
                                                         : FULL_DIVISIONS_DEF / 2;
        for (int k = 0; k < 4; k++) begin
          p = (longint'(fr[k]) * sz) >> 16;
          px[k] = p % w;
          py[k] = p / w;
        end
        sx = px[0];
        sy = py[0];
        for (int k = 0; k < 4; k++) begin
          px[k] = sx * 256 + (px[k] - sx) * sc;
          py[k] = sy * 256 + (py[k] - sy) * sc;
        end
      end else begin
        // full strokes sit on the enlarged virtual canvas
        vw = 0;
        while ((vw + 1) * (vw + 1) <= 2 * w * w) vw++;
        off = (vw - w) / 2;
        divisions = FULL_DIVISIONS_DEF;
        for (int k = 0; k < 4; k++) begin
          p = (longint'(fr[k]) * 2 * sz) >> 16;
          px[k] = (p % vw - off) * 256;
          py[k] = (p / vw - off) * 256;
        end
      end
      e1x = px[0]; e1y = py[0];
      e2x = px[1]; e2y = py[1];
      c1x = px[2]; c1y = py[2];
      c2x = px[3]; c2y = py[3];
      case (mode)
        MODE_BLACK: pen_color = COLOR_BLACK;
        MODE_BW:    pen_color = (it.color_fraction < HALF_OPTION) ? COLOR_BLACK : COLOR_WHITE;
        MODE_BR:    pen_color = (it.color_fraction < HALF_OPTION) ? COLOR_BLACK : COLOR_RED;
        default:
          pen_color = (it.color_fraction < THIRD_OPTION) ? COLOR_BLACK :
                      (it.color_fraction < TWO_THIRD_OPTION) ? COLOR_RED : COLOR_WHITE;
      endcase
      point_no = 0;
      drawing = 1;
    endfunction

    function void plot_point();
      longint n, a, b, w0, w1, w2, w3, den, nx, ny, cx, cy, pxv, pyv, wd, hd;
      int lo;
      bit fin;
      out_item_t r;
      n = divisions;
      if (n < 1) n = 1;
      b = point_no;
      if (b > n) b = n;
      a = n - b;
      w0 = a * a * a;
      w1 = 3 * b * a * a;
      w2 = 3 * b * b * a;
      w3 = b * b * b;
      den = n * n * n * 256;
      nx = w0 * e1x + w1 * c1x + w2 * c2x + w3 * e2x;
      ny = w0 * e1y + w1 * c1y + w2 * c2y + w3 * e2y;
      fin = (b >= n);
      wd = clamp_dim(canvas_w);
      hd = clamp_dim(canvas_h);
      lo = one_pixel ? 0 : -1;
      // pencil tip: dx outer, dy inner
      for (int dx = lo; dx <= -lo; dx++) begin
        for (int dy = lo; dy <= -lo; dy++) begin
          cx = nx + dx * den;
          cy = ny + dy * den;
          pxv = cx / den;
          pyv = cy / den;
          r.pixel_x = pxv[PIX_W-1:0];
          r.pixel_y = pyv[PIX_W-1:0];
          r.color_code = pen_color;
          r.write_enable = (cx >= 0 && cy >= 0 && pxv < wd && pyv < hd);
          r.last_in_run = (dx == -lo && dy == -lo);
          r.stroke_done = fin;
          expected_pixels.push_back(r);
        end
      end
      if (fin) drawing = 0;
      else point_no = (point_no + 1) & 511;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      if (!it.action) begin
        load_stroke(it);
      end else if (!drawing) begin
        // step on an idle stroke gives one dummy pixel
        r = '0;
        r.color_code = pen_color;
        r.last_in_run = 1;
        r.stroke_done = 1;
        expected_pixels.push_back(r);
      end else begin
        plot_point();
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %p", got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.color_code !== want.color_code || got.write_enable !== want.write_enable ||
          got.last_in_run !== want.last_in_run || got.stroke_done !== want.stroke_done) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch: expected %p, got %p", want, got);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [DIM_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_rsp_o;

  stroke_scoreboard sb = new();

  // shared between the request driver and the pixel sink
  bit quiet_gaps = 0;
  bit hold_sink = 0;
  int loads_sent = 0, steps_sent = 0, cfg_writes = 0;

  always #5 clk_i = ~clk_i;

  cubic_bezier_stroke_plotter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // pixel sink: random back-pressure plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_pixel(out_rsp_o);
      if (hold_sink) begin
        hold_sink = 0;
        stall_left = 600;
      end else if (stall_left == 0 && out_ready_i) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one request and wait for its acceptance
  task automatic send_request(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(it);
    if (it.action) steps_sent++;
    else loads_sent++;
  endtask

  task automatic send_load(logic [15:0] len, logic [15:0] e1, logic [15:0] e2,
                           logic [15:0] c1, logic [15:0] c2, logic [15:0] col);
    in_item_t it;
    it.action = 1'b0;
    it.length_fraction = len;
    it.end1_fraction = e1;
    it.end2_fraction = e2;
    it.ctrl1_fraction = c1;
    it.ctrl2_fraction = c2;
    it.color_fraction = col;
    send_request(it);
  endtask

  // step items carry random filler in the unused fields
  task automatic send_steps(int count);
    in_item_t it;
    for (int k = 0; k < count; k++) begin
      it = {1'b1, $urandom, $urandom, $urandom};
      it.action = 1'b1;
      send_request(it);
    end
  endtask

  // pause the sender until every pixel is out and any load has finished
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [DIM_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic write_all(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [1:0] m, logic t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, {9'd0, m});
    write_reg(REG_TIP, {10'd0, t});
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 11'd1;
      1: return 11'd1024;
      2: return 11'd0;
      3: return 11'd2047;
      4: return 11'($urandom_range(2, 40));
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  // random length fraction weighted toward short strokes
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 39321));
    if (r < 8) return 16'($urandom_range(39322, 58982));
    return 16'($urandom_range(58983, 65535));
  endfunction

  initial begin
    int budget, nsteps, r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle step, then extremes under the reset settings
    send_steps(1);
    send_load(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_steps(2);
    send_load(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_steps(2);
    drain();
    write_all(11'd1024, 11'd1, MODE_BRW, 1'b1);
    send_load(16'd39321, 16'd0, 16'hffff, 16'h8000, 16'h4000, 16'd21823);
    send_steps(1);
    send_load(16'd39322, 16'hffff, 16'd0, 16'h1234, 16'hedcb, 16'd21824);
    send_steps(1);
    send_load(16'd58982, 16'h7fff, 16'h8000, 16'h0001, 16'hfffe, 16'd43646);
    send_steps(1);
    send_load(16'd58983, 16'h0001, 16'hfffe, 16'hffff, 16'h0000, 16'd43647);
    send_steps(1);
    drain();
    write_all(11'd0, 11'd2047, MODE_BW, 1'b0);
    send_load(16'd0, 16'h8000, 16'hffff, 16'h0000, 16'h4000, 16'd32767);
    send_steps(1);
    send_load(16'd0, 16'h8000, 16'h0000, 16'hffff, 16'hc000, 16'd32768);
    send_steps(2);
    drain();

    // random phases, each under its own settings
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      if (phase == 11) write_all(11'd256, 11'd256, MODE_BR, 1'b0);
      else write_all(pick_dim(), pick_dim(), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
      quiet_gaps = (phase % 4 == 3);
      if (phase == 5) begin
        quiet_gaps = 1;
        hold_sink = 1;
      end
      budget = 12;
      while (budget > 0) begin
        r = $urandom_range(0, 99);
        if (r < 85 || (phase == 2 && budget == 12)) begin
          // once, run a quarter stroke to its end and one idle step past it
          nsteps = (phase == 2 && budget == 12) ? 102 : $urandom_range(1, 20);
          send_load((nsteps == 102) ? 16'($urandom_range(0, 39321)) : pick_length(),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
          send_steps(nsteps);
          budget = budget - 1 - nsteps;
        end else if (r < 93) begin
          send_steps(1);
          budget--;
        end else begin
          // a load with no steps of its own, usually abandoned by the next load
          send_load(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
          budget--;
        end
      end
    end

    drain();
    $display("covered %0d loads, %0d steps, %0d pixels, %0d register writes",
             loads_sent, steps_sent, sb.pixels_seen, cfg_writes);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
